@@ design/sorted_table_find_swap_or_insert_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Shared concurrent-assertion wrappers, clocked on aclk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_FIND_SWAP_OR_INSERT_ASSERT_SVH
`define SORTED_TABLE_FIND_SWAP_OR_INSERT_ASSERT_SVH

// same-cycle implication
`define STFSI_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STFSI_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/stfsi_pkg.sv @@
// ----------------------------------------------------------------------------
// stfsi_pkg
// Sizes and result codes for the sorted key table.
// ----------------------------------------------------------------------------
package stfsi_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int IDX_W       = 5;

    localparam int IN_TDATA_W  = ((KEY_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CNT_W + KEY_W + CNT_W + 7) / 8) * 8;
    localparam int STATUS_W    = 3;

    localparam logic CMD_FIND = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_SWAPPED  = 3'd0,
        STS_AT_END   = 3'd1,
        STS_INSERTED = 3'd2,
        STS_FULL     = 3'd3,
        STS_READ     = 3'd4
    } status_t;

endpackage

@@ design/sorted_table_find_swap_or_insert.sv @@
// ----------------------------------------------------------------------------
// sorted_table_find_swap_or_insert
// Ascending table of distinct signed keys: find then swap or insert, or read.
// ----------------------------------------------------------------------------
// The keys live in one single-port-write, registered-read memory. A read
// request registers the read data and then the result (the result alone
// when the index is beyond the count). A find request runs a binary
// search in which each probe is an address state, then a compare of the
// registered read data. A hit then swaps with its successor, if it has
// one, writing the successor down and then the key up; a miss inserts,
// unless the table is full, by moving every larger entry up one place,
// one memory read and one write per cycle. A result may wait in the output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
module sorted_table_find_swap_or_insert
    import stfsi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key[31:0], index[36:32]
    input  logic [0:0]             s_tuser,   // cmd[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // position[5:0], entry_value[37:6],
                                              // entry_count[43:38]
    output logic [STATUS_W-1:0]    m_tuser    // status[2:0]
);

`include "sorted_table_find_swap_or_insert_assert.svh"

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_RD     = 10'b0000000010,
        ST_SRCH   = 10'b0000000100,
        ST_CMP    = 10'b0000001000,
        ST_LAST   = 10'b0000010000,
        ST_SWP_W1 = 10'b0000100000,
        ST_SWP_W2 = 10'b0001000000,
        ST_INS    = 10'b0010000000,
        ST_RESULT = 10'b0100000000,
        ST_SPARE  = 10'b1000000000
    } state_t;

    logic [KEY_W-1:0] mem [TABLE_DEPTH];

    state_t                  state_reg, state_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]       lo_reg, lo_next;
    logic [ADDR_W-1:0]       hi_reg, hi_next;
    logic [ADDR_W-1:0]       probe_reg, probe_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        sh_reg, sh_next;
    logic                    pend_reg, pend_next;
    logic [ADDR_W-1:0]       pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    status_t                 status_reg, status_next;
    logic [KEY_W-1:0]        val_reg, val_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]     m_tuser_reg, m_tuser_next;
    logic [KEY_W-1:0]        rdata_reg;

    logic                    mem_re, mem_we;
    logic [ADDR_W-1:0]       mem_raddr, mem_waddr;
    logic [KEY_W-1:0]        mem_wdata;

    logic signed [KEY_W-1:0] entry;
    logic                    hit;
    logic                    resolve;
    logic                    res_found;
    logic [CNT_W-1:0]        res_pos;
    logic [CNT_W-1:0]        res_succ;
    logic [ADDR_W:0]         mid_sum;
    logic [IDX_W-1:0]        in_idx;
    logic                    slot_free;
    logic                    shift_wr;

    assign entry     = $signed(rdata_reg);
    assign hit       = (entry == key_reg);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign in_idx    = s_tdata[KEY_W +: IDX_W];
    assign slot_free = !m_tvalid_reg || m_tready;
    assign res_succ  = res_pos + CNT_W'(1);
    assign shift_wr  = (state_reg == ST_INS) && pend_reg;

    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        probe_next     = probe_reg;
        pos_next       = pos_reg;
        sh_next        = sh_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        val_next       = val_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        mem_re         = 1'b0;
        mem_raddr      = probe_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[ADDR_W-1:0];
        mem_wdata      = key_reg;
        resolve        = 1'b0;
        res_found      = 1'b0;
        res_pos        = {1'b0, probe_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next = $signed(s_tdata[KEY_W-1:0]);
                    if (s_tuser[0] == CMD_READ) begin
                        pos_next    = CNT_W'(in_idx);
                        status_next = STS_READ;
                        if (CNT_W'(in_idx) < count_reg) begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(in_idx);
                            state_next = ST_RD;
                        end else begin
                            val_next   = '0;
                            state_next = ST_RESULT;
                        end
                    end else begin
                        val_next = s_tdata[KEY_W-1:0];
                        if (count_reg == '0) begin
                            pos_next    = '0;
                            status_next = STS_INSERTED;
                            sh_next     = '0;
                            pend_next   = 1'b0;
                            state_next  = ST_INS;
                        end else begin
                            lo_next    = '0;
                            hi_next    = ADDR_W'(count_reg - CNT_W'(1));
                            state_next = ST_SRCH;
                        end
                    end
                end
            end
            ST_RD: begin
                val_next   = rdata_reg;
                state_next = ST_RESULT;
            end
            ST_SRCH: begin
                mem_re = 1'b1;
                if (lo_reg < hi_reg) begin
                    probe_next = mid_sum[ADDR_W:1];
                    mem_raddr  = mid_sum[ADDR_W:1];
                    state_next = ST_CMP;
                end else begin
                    probe_next = lo_reg;
                    mem_raddr  = lo_reg;
                    state_next = ST_LAST;
                end
            end
            ST_CMP: begin
                if (hit) begin
                    resolve   = 1'b1;
                    res_found = 1'b1;
                end else if (entry > key_reg) begin
                    hi_next    = probe_reg;
                    state_next = ST_SRCH;
                end else begin
                    lo_next    = probe_reg + ADDR_W'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_LAST: begin
                resolve   = 1'b1;
                res_found = hit;
                if (!hit && entry < key_reg) begin
                    res_pos = {1'b0, probe_reg} + CNT_W'(1);
                end
            end
            ST_SWP_W1: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[ADDR_W-1:0];
                mem_wdata  = rdata_reg;
                state_next = ST_SWP_W2;
            end
            ST_SWP_W2: begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(pos_reg + CNT_W'(1));
                mem_wdata  = key_reg;
                state_next = ST_RESULT;
            end
            ST_INS: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = rdata_reg;
                end
                if (sh_reg > pos_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = ADDR_W'(sh_reg - CNT_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = sh_reg[ADDR_W-1:0];
                    sh_next        = sh_reg - CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_reg[ADDR_W-1:0];
                        mem_wdata  = key_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({count_reg, val_reg, pos_reg});
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (resolve) begin
            pos_next = res_pos;
            if (res_found) begin
                if (res_succ < count_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = res_succ[ADDR_W-1:0];
                    status_next = STS_SWAPPED;
                    state_next  = ST_SWP_W1;
                end else begin
                    status_next = STS_AT_END;
                    state_next  = ST_RESULT;
                end
            end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                status_next = STS_FULL;
                state_next  = ST_RESULT;
            end else begin
                status_next = STS_INSERTED;
                sh_next     = count_reg;
                pend_next   = 1'b0;
                state_next  = ST_INS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        probe_reg     <= probe_next;
        pos_reg       <= pos_next;
        sh_reg        <= sh_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        val_reg       <= val_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `STFSI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "count over depth")
    `STFSI_ASSERT_NXT(a_count_hold, state_reg != ST_INS, $stable(count_reg), "count moved")
    `STFSI_ASSERT_IMP(a_shift_above, shift_wr, CNT_W'(pend_addr_reg) > pos_reg, "shift too low")
    `STFSI_ASSERT_IMP(a_result_src, $rose(m_tvalid_reg), $past(state_reg) == ST_RESULT, "orphan")

endmodule
